// File: rtl/ac_pkg.sv
package ac_pkg;

	localparam int MAX_NODES     = 1024;
	localparam int ALPHABET_SIZE = 26;

	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int NCOUNT_W  = $clog2(MAX_NODES + 1);
	localparam int SYM_W     = 5;
	localparam int ACT_W     = 3;
	localparam int COUNT_W   = 16;
	localparam int STATUS_W  = 2;

	localparam int CHILD_DEPTH = MAX_NODES * ALPHABET_SIZE;
	localparam int CHILD_AW    = $clog2(CHILD_DEPTH);

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam logic [ACT_W-1:0] ACT_INSERT  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_END     = 3'd1;
	localparam logic [ACT_W-1:0] ACT_BUILD   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_MATCH   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_RESTART = 3'd4;
	localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd5;

	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

	// Flat address of a child slot: node times alphabet size plus symbol.
	function automatic logic [CHILD_AW-1:0] child_addr(input logic [NODE_W-1:0] node,
			input logic [SYM_W-1:0] sym);
		logic [CHILD_AW-1:0] base;
		base = CHILD_AW'(node) * CHILD_AW'(ALPHABET_SIZE);
		return base + CHILD_AW'(sym);
	endfunction

endpackage

// File: rtl/aho_corasick_matcher.sv
// Aho-Corasick matcher: one word in, one result word out, one item at a time.
// Restart, unused actions and range errors go straight to the result; an insert that
// allocates a node also clears that node's child row. Match walks failure links until a
// child is found or the root is reached; build walks the trie breadth-first and runs the
// same failure walk for each node below the root's children. All cost is set by the single
// port of each table RAM. After reset, and after a clear, a pass clears the root row; no
// word is accepted during that pass.
module aho_corasick_matcher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [4:0] symbol, [7:5] zero
	input  logic [2:0]  s_axis_tuser,   // [2:0] action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [15:0] match_count, [26:16] nodes_used, rest zero
	output logic [1:0]  m_axis_tuser    // [1:0] status
);
	import ac_pkg::*;

	// Sequencer states. The failure walk (ST_A_*) is shared by match and build.
	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_CLR    = 5'd1;
	localparam logic [4:0] ST_I_RD   = 5'd2;
	localparam logic [4:0] ST_I_CHK  = 5'd3;
	localparam logic [4:0] ST_E_RD   = 5'd4;
	localparam logic [4:0] ST_E_WR   = 5'd5;
	localparam logic [4:0] ST_A_RD   = 5'd6;
	localparam logic [4:0] ST_A_CHK  = 5'd7;
	localparam logic [4:0] ST_A_FL   = 5'd8;
	localparam logic [4:0] ST_A_END  = 5'd9;
	localparam logic [4:0] ST_M_TOT  = 5'd10;
	localparam logic [4:0] ST_B_INIT = 5'd11;
	localparam logic [4:0] ST_B_ROOT = 5'd12;
	localparam logic [4:0] ST_B_DEQ  = 5'd13;
	localparam logic [4:0] ST_B_CUR  = 5'd14;
	localparam logic [4:0] ST_B_FCUR = 5'd15;
	localparam logic [4:0] ST_B_KID  = 5'd16;
	localparam logic [4:0] ST_B_KCHK = 5'd17;
	localparam logic [4:0] ST_B_SUM  = 5'd18;
	localparam logic [4:0] ST_B_WR   = 5'd19;
	localparam logic [4:0] ST_DONE   = 5'd20;

	logic [4:0]          state_q;
	logic                init_q;        // clear pass started by reset gives no result
	logic [NCOUNT_W-1:0] nc_q;          // nodes in use, root included
	logic [NODE_W-1:0]   ic_q;          // insert cursor
	logic [NODE_W-1:0]   mc_q;          // match cursor
	logic [NODE_W-1:0]   v_q;           // node under the failure walk
	logic [SYM_W-1:0]    asym_q;        // symbol that the failure walk looks for
	logic                adv_build_q;   // failure walk was called by the build
	logic [SYM_W-1:0]    sym_q;
	logic [NODE_W-1:0]   clr_node_q;    // node whose child row is being cleared
	logic [SYM_W-1:0]    k_q;           // slot counter for row clear and build
	logic [NODE_W-1:0]   cur_q;
	logic [NODE_W-1:0]   fcur_q;
	logic [NODE_W-1:0]   nxt_q;
	logic [NCOUNT_W-1:0] head_q;
	logic [NCOUNT_W-1:0] tail_q;
	logic [COUNT_W-1:0]  res_count_q;
	logic [STATUS_W-1:0] res_status_q;
	logic                out_valid_q;
	logic [COUNT_W-1:0]  out_count_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [NCOUNT_W-1:0] out_nodes_q;

	// Table RAM ports.
	logic                child_we, fail_we, own_we, tot_we, q_we;
	logic [CHILD_AW-1:0] child_addr_w;
	logic [NODE_W-1:0]   child_wd, child_rd;
	logic [NODE_W-1:0]   fail_addr, fail_wd, fail_rd;
	logic [NODE_W-1:0]   own_addr, tot_addr, q_addr;
	logic [COUNT_W-1:0]  own_wd, own_rd, tot_wd, tot_rd;
	logic [NODE_W-1:0]   q_wd, q_rd;
	logic [NODE_W-1:0]   cn;
	logic [SYM_W-1:0]    cs;

	logic                accept;
	logic                sym_bad;
	logic                table_full;
	logic                queue_room;
	logic                row_last;
	logic                out_free;
	logic [COUNT_W:0]    sum_w;
	logic [COUNT_W-1:0]  sum_sat;

	assign accept     = s_axis_tvalid && s_axis_tready;
	assign sym_bad    = s_axis_tdata[SYM_W-1:0] >= SYM_W'(ALPHABET_SIZE);
	assign table_full = nc_q == NCOUNT_W'(MAX_NODES);
	assign queue_room = tail_q < NCOUNT_W'(MAX_NODES);
	assign row_last   = k_q == SYM_W'(ALPHABET_SIZE - 1);
	assign out_free   = !out_valid_q || m_axis_tready;

	// Build sum: own count plus the failure target's total, saturated.
	assign sum_w   = {1'b0, own_rd} + {1'b0, tot_rd};
	assign sum_sat = sum_w[COUNT_W] ? COUNT_MAX : sum_w[COUNT_W-1:0];

	// Child table port: which node row and slot are addressed in each state.
	always_comb begin
		cn       = v_q;
		cs       = asym_q;
		child_we = 1'b0;
		child_wd = '0;
		case (state_q)
			ST_CLR: begin
				cn       = clr_node_q;
				cs       = k_q;
				child_we = 1'b1;
			end
			ST_I_RD: begin
				cn = ic_q;
				cs = sym_q;
			end
			ST_I_CHK: begin
				cn       = ic_q;
				cs       = sym_q;
				child_we = (child_rd == '0) && !table_full;
				child_wd = nc_q[NODE_W-1:0];
			end
			ST_B_KID: begin
				cn = cur_q;
				cs = k_q;
			end
			default: begin
				cn = v_q;
				cs = asym_q;
			end
		endcase
	end

	assign child_addr_w = child_addr(cn, cs);

	// Node tables: failure link, own count, total count, and the breadth-first queue.
	always_comb begin
		fail_addr = v_q;
		fail_we   = 1'b0;
		fail_wd   = '0;
		own_addr  = ic_q;
		own_we    = 1'b0;
		own_wd    = '0;
		tot_addr  = v_q;
		tot_we    = 1'b0;
		tot_wd    = '0;
		q_addr    = head_q[NODE_W-1:0];
		q_we      = 1'b0;
		q_wd      = child_rd;
		case (state_q)
			ST_CLR: begin
				fail_addr = clr_node_q;
				fail_we   = k_q == '0;
				own_addr  = clr_node_q;
				own_we    = k_q == '0;
				tot_addr  = clr_node_q;
				tot_we    = k_q == '0;
			end
			ST_E_WR: begin
				own_we = own_rd != COUNT_MAX;
				own_wd = own_rd + COUNT_W'(1);
			end
			ST_B_INIT: begin
				fail_addr = '0;
				fail_we   = 1'b1;
				own_addr  = '0;
				q_addr    = '0;
				q_we      = 1'b1;
				q_wd      = '0;
			end
			ST_B_ROOT: begin
				tot_addr = '0;
				tot_we   = 1'b1;
				tot_wd   = own_rd;
			end
			ST_B_CUR: begin
				fail_addr = q_rd;
			end
			ST_B_KCHK: begin
				q_addr = tail_q[NODE_W-1:0];
				q_we   = (child_rd != '0) && queue_room;
			end
			ST_B_SUM: begin
				fail_addr = nxt_q;
				fail_we   = 1'b1;
				fail_wd   = v_q;
				own_addr  = nxt_q;
			end
			ST_B_WR: begin
				tot_addr = nxt_q;
				tot_we   = 1'b1;
				tot_wd   = sum_sat;
			end
			default: begin
			end
		endcase
	end

	ac_ram #(.WIDTH(NODE_W), .DEPTH(CHILD_DEPTH)) u_child (
		.clk(clk), .we(child_we), .addr(child_addr_w), .wdata(child_wd), .rdata(child_rd)
	);
	ac_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_fail (
		.clk(clk), .we(fail_we), .addr(fail_addr), .wdata(fail_wd), .rdata(fail_rd)
	);
	ac_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_NODES)) u_own (
		.clk(clk), .we(own_we), .addr(own_addr), .wdata(own_wd), .rdata(own_rd)
	);
	ac_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_NODES)) u_total (
		.clk(clk), .we(tot_we), .addr(tot_addr), .wdata(tot_wd), .rdata(tot_rd)
	);
	ac_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (
		.clk(clk), .we(q_we), .addr(q_addr), .wdata(q_wd), .rdata(q_rd)
	);

	assign s_axis_tready = state_q == ST_IDLE;

	// Sequencer. Cursors and the node count live here; the tables live in the RAMs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			init_q       <= 1'b1;
			nc_q         <= NCOUNT_W'(1);
			ic_q         <= '0;
			mc_q         <= '0;
			v_q          <= '0;
			asym_q       <= '0;
			sym_q        <= '0;
			cur_q        <= '0;
			fcur_q       <= '0;
			nxt_q        <= '0;
			res_count_q  <= '0;
			res_status_q <= STAT_OK;
			clr_node_q   <= '0;
			k_q          <= '0;
			adv_build_q  <= 1'b0;
			head_q       <= '0;
			tail_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_count_q  <= '0;
						res_status_q <= STAT_OK;
						sym_q        <= s_axis_tdata[SYM_W-1:0];
						asym_q       <= s_axis_tdata[SYM_W-1:0];
						v_q          <= mc_q;
						adv_build_q  <= 1'b0;
						init_q       <= 1'b0;
						case (s_axis_tuser)
							ACT_INSERT: begin
								if (sym_bad) begin
									res_status_q <= STAT_RANGE;
									state_q      <= ST_DONE;
								end else begin
									state_q <= ST_I_RD;
								end
							end
							ACT_END:   state_q <= ST_E_RD;
							ACT_BUILD: state_q <= ST_B_INIT;
							ACT_MATCH: begin
								if (sym_bad) begin
									res_status_q <= STAT_RANGE;
									state_q      <= ST_DONE;
								end else begin
									state_q <= ST_A_RD;
								end
							end
							ACT_RESTART: begin
								mc_q    <= '0;
								state_q <= ST_DONE;
							end
							ACT_CLEAR: begin
								nc_q       <= NCOUNT_W'(1);
								ic_q       <= '0;
								mc_q       <= '0;
								clr_node_q <= '0;
								k_q        <= '0;
								state_q    <= ST_CLR;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_CLR: begin
					k_q <= k_q + SYM_W'(1);
					if (row_last) begin
						state_q <= init_q ? ST_IDLE : ST_DONE;
					end
				end
				ST_I_RD: state_q <= ST_I_CHK;
				ST_I_CHK: begin
					if (child_rd != '0) begin
						ic_q    <= child_rd;
						state_q <= ST_DONE;
					end else if (table_full) begin
						res_status_q <= STAT_FULL;
						state_q      <= ST_DONE;
					end else begin
						// New node: link it, then clear its child row and node entries.
						ic_q       <= nc_q[NODE_W-1:0];
						clr_node_q <= nc_q[NODE_W-1:0];
						nc_q       <= nc_q + NCOUNT_W'(1);
						k_q        <= '0;
						state_q    <= ST_CLR;
					end
				end
				ST_E_RD: state_q <= ST_E_WR;
				ST_E_WR: begin
					ic_q    <= '0;
					state_q <= ST_DONE;
				end
				ST_A_RD: state_q <= ST_A_CHK;
				ST_A_CHK: begin
					if (child_rd != '0) begin
						v_q     <= child_rd;
						state_q <= ST_A_END;
					end else if (v_q == '0) begin
						state_q <= ST_A_END;
					end else begin
						state_q <= ST_A_FL;
					end
				end
				ST_A_FL: begin
					v_q     <= fail_rd;
					state_q <= ST_A_RD;
				end
				ST_A_END: state_q <= adv_build_q ? ST_B_SUM : ST_M_TOT;
				ST_M_TOT: begin
					mc_q        <= v_q;
					res_count_q <= tot_rd;
					state_q     <= ST_DONE;
				end
				ST_B_INIT: begin
					head_q  <= '0;
					tail_q  <= NCOUNT_W'(1);
					state_q <= ST_B_ROOT;
				end
				ST_B_ROOT: state_q <= ST_B_DEQ;
				ST_B_DEQ: begin
					if (head_q == tail_q) begin
						state_q <= ST_DONE;
					end else begin
						head_q  <= head_q + NCOUNT_W'(1);
						state_q <= ST_B_CUR;
					end
				end
				ST_B_CUR: begin
					cur_q   <= q_rd;
					state_q <= ST_B_FCUR;
				end
				ST_B_FCUR: begin
					fcur_q  <= fail_rd;
					k_q     <= '0;
					state_q <= ST_B_KID;
				end
				ST_B_KID: begin
					state_q <= (k_q == SYM_W'(ALPHABET_SIZE)) ? ST_B_DEQ : ST_B_KCHK;
				end
				ST_B_KCHK: begin
					if (child_rd == '0) begin
						k_q     <= k_q + SYM_W'(1);
						state_q <= ST_B_KID;
					end else begin
						nxt_q <= child_rd;
						if (queue_room) begin
							tail_q <= tail_q + NCOUNT_W'(1);
						end
						if (cur_q == '0) begin
							// Children of the root fail to the root.
							v_q     <= '0;
							state_q <= ST_B_SUM;
						end else begin
							v_q         <= fcur_q;
							asym_q      <= k_q;
							adv_build_q <= 1'b1;
							state_q     <= ST_A_RD;
						end
					end
				end
				ST_B_SUM: state_q <= ST_B_WR;
				ST_B_WR: begin
					k_q     <= k_q + SYM_W'(1);
					state_q <= ST_B_KID;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register: loaded when a result is done and the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_count_q  <= res_count_q;
			out_status_q <= res_status_q;
			out_nodes_q  <= nc_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(32 - COUNT_W - NCOUNT_W){1'b0}}, out_nodes_q, out_count_q};
	assign m_axis_tuser  = out_status_q;

	// The node count always covers the root and never passes the table size.
	a_nodes_range: assert property (@(posedge clk) disable iff (!arst_n)
		nc_q != '0 && nc_q <= NCOUNT_W'(MAX_NODES))
		else $error("node count out of range");

	// Both cursors point at allocated nodes.
	a_cursors: assert property (@(posedge clk) disable iff (!arst_n)
		NCOUNT_W'(ic_q) < nc_q && NCOUNT_W'(mc_q) < nc_q)
		else $error("cursor beyond allocated nodes");

	// A new result is only ever loaded from the finishing state.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == ST_DONE)
		else $error("result produced outside the finishing state");

endmodule

// File: rtl/ac_ram.sv
module ac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
